@@ sv/tpgs_pkg.sv @@
// shared types, codes and small tables for the tile packet gather/scatter unit
// used by the top level of the block; depends on nothing
package tpgs_pkg;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV1 = 7'b0000010,
        ST_DIV2 = 7'b0000100,
        ST_DIV3 = 7'b0001000,
        ST_DIV4 = 7'b0010000,
        ST_EMIT = 7'b0100000,
        ST_RESP = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_READ   = 2'd1,
        REQ_PACK   = 2'd2,
        REQ_UNPACK = 2'd3
    } req_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_REJECTED = 2'd1;
    localparam logic [1:0] STATUS_OVERSIZE = 2'd2;

    localparam logic [2:0] FMT_FP8  = 3'd0;
    localparam logic [2:0] FMT_FP16 = 3'd2;
    localparam logic [2:0] FMT_FP32 = 3'd4;

    localparam logic [2:0] LAYOUT_A_LINE    = 3'd0;
    localparam logic [2:0] LAYOUT_B_LINE    = 3'd1;
    localparam logic [2:0] LAYOUT_ROW_MAJOR = 3'd2;
    localparam logic [2:0] LAYOUT_C_SUBTILE = 3'd3;

    localparam logic [2:0] CFG_ELEM_FORMAT     = 3'd0;
    localparam logic [2:0] CFG_LAYOUT_MODE     = 3'd1;
    localparam logic [2:0] CFG_TILES_PER_ROW   = 3'd2;
    localparam logic [2:0] CFG_PACKETS_IN_TILE = 3'd3;
    localparam logic [2:0] CFG_ROWS_IN_PACKET  = 3'd4;
    localparam logic [2:0] CFG_COLS_IN_PACKET  = 3'd5;
    localparam logic [2:0] CFG_SHAPE_ROWS      = 3'd6;
    localparam logic [2:0] CFG_SHAPE_COLS      = 3'd7;

    localparam int TILE_DIM = 16;
    localparam int HALF_DIM = 8;

    // log2 of bytes per element; valid only for supported formats
    function automatic logic [1:0] elem_shift(input logic [2:0] fmt);
        logic [1:0] s;
        unique case (fmt)
            3'd0, 3'd1: s = 2'd0;
            3'd2, 3'd3: s = 2'd1;
            default:    s = 2'd2;
        endcase
        return s;
    endfunction

    // packets across a tile row in row-major layout: ceil(16 / cols)
    function automatic logic [7:0] rm_per(input logic [4:0] cols);
        logic [7:0] p;
        unique case (cols)
            5'd1:                       p = 8'd16;
            5'd2:                       p = 8'd8;
            5'd3:                       p = 8'd6;
            5'd4, 5'd5:                 p = 8'd4;
            5'd6, 5'd7:                 p = 8'd3;
            5'd8, 5'd9, 5'd10, 5'd11,
            5'd12, 5'd13, 5'd14, 5'd15: p = 8'd2;
            default:                    p = 8'd1;
        endcase
        return p;
    endfunction

endpackage

@@ sv/tpgs_div.sv @@
// iterative restoring divider, 16-bit dividend by 8-bit divisor, one bit a cycle
// depends on nothing; divisor must hold steady while busy
module tpgs_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [15:0] quot,
    output logic [7:0]  rmd
);

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] q_reg;
    logic [7:0]  r_reg;
    logic [8:0]  r_sh;
    logic        ge;
    logic [8:0]  r_sub;

    assign r_sh  = {r_reg, q_reg[15]};
    assign ge    = r_sh >= {1'b0, divisor};
    assign r_sub = ge ? (r_sh - {1'b0, divisor}) : r_sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
        end else if (busy_reg) begin
            q_reg <= {q_reg[14:0], ge};
            r_reg <= r_sub[7:0];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rmd  = r_reg;

endmodule

@@ sv/tpgs_store.sv @@
// payload byte store, single port, registered read data held between reads
// depends on nothing
module tpgs_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          aclk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/tile_packet_gather_scatter_unit.sv @@
// top level of the tile packet gather/scatter unit
// uses tpgs_pkg, tpgs_div (region mapping divides) and tpgs_store (payload memory)

// One request is taken at a time. Byte write and read requests go straight to the
// response state. A pack or unpack request first maps its packet index through three
// divisions on one shared bit-serial divider; an unpack adds a fourth when its byte
// slot lies inside the packet. A pack then streams PACKET_BYTES transfers at one per
// cycle while the result side keeps taking them, each byte that lies inside the packet
// and the region read from the single-port payload memory and the rest given as zero.
// A rejected or oversize request gives one transfer straight away. The payload memory
// has no reset: a byte must be written before it is read.
module tile_packet_gather_scatter_unit #(
    parameter int PACKET_BYTES  = 64,
    parameter int PAYLOAD_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // packet_index[15:0], transposed[16], payload_addr[28:17], byte_slot[34:29],
    // byte_in[42:35], zero pad[47:43]
    input  logic [47:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // byte_out[7:0], slot_out[13:8], zero pad[15:14]
    output logic [15:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_data
);

    localparam int AW = $clog2(PAYLOAD_BYTES);
    localparam int KW = $clog2(PACKET_BYTES + 1);

    // configuration registers
    logic [2:0] elem_format_reg;
    logic [2:0] layout_mode_reg;
    logic [7:0] tiles_per_row_reg;
    logic [7:0] packets_in_tile_reg;
    logic [4:0] rows_in_packet_reg;
    logic [4:0] cols_in_packet_reg;
    logic [7:0] shape_rows_reg;
    logic [7:0] shape_cols_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_format_reg     <= 3'd0;
            layout_mode_reg     <= 3'd2;
            tiles_per_row_reg   <= 8'd1;
            packets_in_tile_reg <= 8'd1;
            rows_in_packet_reg  <= 5'd4;
            cols_in_packet_reg  <= 5'd16;
            shape_rows_reg      <= 8'd16;
            shape_cols_reg      <= 8'd16;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                tpgs_pkg::CFG_ELEM_FORMAT:     elem_format_reg     <= cfg_data[2:0];
                tpgs_pkg::CFG_LAYOUT_MODE:     layout_mode_reg     <= cfg_data[2:0];
                tpgs_pkg::CFG_TILES_PER_ROW:   tiles_per_row_reg   <= cfg_data;
                tpgs_pkg::CFG_PACKETS_IN_TILE: packets_in_tile_reg <= cfg_data;
                tpgs_pkg::CFG_ROWS_IN_PACKET:  rows_in_packet_reg  <= cfg_data[4:0];
                tpgs_pkg::CFG_COLS_IN_PACKET:  cols_in_packet_reg  <= cfg_data[4:0];
                tpgs_pkg::CFG_SHAPE_ROWS:      shape_rows_reg      <= cfg_data;
                default:                       shape_cols_reg      <= cfg_data;
            endcase
        end
    end

    // request fields
    logic [1:0]  in_req;
    logic [15:0] in_idx;
    logic        in_tr;
    logic [11:0] in_addr;
    logic [5:0]  in_slot;
    logic [7:0]  in_byte;

    assign in_req  = s_tuser;
    assign in_idx  = s_tdata[15:0];
    assign in_tr   = s_tdata[16];
    assign in_addr = s_tdata[28:17];
    assign in_slot = s_tdata[34:29];
    assign in_byte = s_tdata[42:35];

    // format / layout checks, all from configuration
    logic [1:0]  sh;
    logic [6:0]  rowlen;
    logic [9:0]  rc_prod;
    logic [11:0] total;
    logic        fmt_bad;
    logic        reject;
    logic        oversize;
    logic        fmt_fp8;
    logic        fmt_fp16;
    logic        fmt_fp32;

    assign sh       = tpgs_pkg::elem_shift(elem_format_reg);
    assign rowlen   = 7'({2'b00, cols_in_packet_reg} << sh);
    assign rc_prod  = rows_in_packet_reg * cols_in_packet_reg;
    assign total    = 12'({2'b00, rc_prod} << sh);
    assign fmt_fp8  = elem_format_reg == tpgs_pkg::FMT_FP8;
    assign fmt_fp16 = elem_format_reg == tpgs_pkg::FMT_FP16;
    assign fmt_fp32 = elem_format_reg == tpgs_pkg::FMT_FP32;
    assign fmt_bad  = elem_format_reg > tpgs_pkg::FMT_FP32;

    always_comb begin
        reject = fmt_bad || shape_rows_reg == 8'd0 || shape_cols_reg == 8'd0 ||
                 tiles_per_row_reg == 8'd0 || packets_in_tile_reg == 8'd0 ||
                 layout_mode_reg > tpgs_pkg::LAYOUT_C_SUBTILE;
        if ((layout_mode_reg == tpgs_pkg::LAYOUT_A_LINE ||
             layout_mode_reg == tpgs_pkg::LAYOUT_B_LINE) && !fmt_fp8 && !fmt_fp16) begin
            reject = 1'b1;
        end
        if (layout_mode_reg == tpgs_pkg::LAYOUT_C_SUBTILE &&
            !fmt_fp8 && !fmt_fp16 && !fmt_fp32) begin
            reject = 1'b1;
        end
        if (layout_mode_reg == tpgs_pkg::LAYOUT_ROW_MAJOR && cols_in_packet_reg == 5'd0) begin
            reject = 1'b1;
        end
    end

    assign oversize = 32'(total) > 32'(PACKET_BYTES);

    // packets sharing one row group of the tile
    logic [7:0] per;

    always_comb begin
        priority if (layout_mode_reg == tpgs_pkg::LAYOUT_ROW_MAJOR) begin
            per = tpgs_pkg::rm_per(cols_in_packet_reg);
        end else if (layout_mode_reg == tpgs_pkg::LAYOUT_C_SUBTILE) begin
            per = fmt_fp8 ? 8'd1 : (fmt_fp16 ? 8'd2 : 8'd4);
        end else begin
            per = fmt_fp8 ? 8'd2 : 8'd4;
        end
    end

    // control state
    tpgs_pkg::state_t state_reg, state_next;
    logic        div_start_reg;
    logic [1:0]  req_reg;
    logic [15:0] idx_reg;
    logic        tr_reg;
    logic [5:0]  slot_reg;
    logic [7:0]  din_reg;
    logic [15:0] tile_reg;
    logic [7:0]  local_reg;
    logic [23:0] region_row_base_reg;
    logic [23:0] region_col_base_reg;
    logic [1:0]  resp_status_reg;
    logic [5:0]  resp_slot_reg;
    logic        resp_rd_reg;
    logic [KW-1:0] emit_counter_reg;
    logic [KW-1:0] row_cnt_reg;
    logic [6:0]    rem_cnt_reg;

    // divider
    logic        div_done;
    logic [15:0] div_quot;
    logic [7:0]  div_rmd;
    logic [15:0] div_a;
    logic [7:0]  div_b;

    always_comb begin
        unique case (state_reg)
            tpgs_pkg::ST_DIV1: begin
                div_a = idx_reg;
                div_b = packets_in_tile_reg;
            end
            tpgs_pkg::ST_DIV2: begin
                div_a = tile_reg;
                div_b = tiles_per_row_reg;
            end
            tpgs_pkg::ST_DIV3: begin
                div_a = {8'd0, local_reg};
                div_b = per;
            end
            default: begin
                div_a = {10'd0, slot_reg};
                div_b = {1'b0, rowlen};
            end
        endcase
    end

    tpgs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (div_quot),
        .rmd      (div_rmd)
    );

    // byte address of one element byte inside the region
    logic        is_emit;
    logic [6:0]  row_off;
    logic [6:0]  rem_sel;
    logic [23:0] calc_r;
    logic [23:0] calc_c;
    logic [1:0]  calc_b;
    logic        calc_tr;
    logic        calc_in_shape;
    logic [15:0] calc_prod;
    logic [18:0] calc_off;
    logic [31:0] calc_off_w;
    logic        calc_in_store;
    logic        calc_ok;

    assign is_emit = state_reg == tpgs_pkg::ST_EMIT;
    assign row_off = is_emit ? 7'(row_cnt_reg) : div_quot[6:0];
    assign rem_sel = is_emit ? rem_cnt_reg : div_rmd[6:0];
    assign calc_r  = region_row_base_reg + 24'(row_off);
    assign calc_c  = region_col_base_reg + 24'(rem_sel >> sh);
    assign calc_b  = rem_sel[1:0] & 2'((3'd1 << sh) - 3'd1);
    assign calc_tr = is_emit && tr_reg;
    assign calc_in_shape = calc_r < 24'(shape_rows_reg) && calc_c < 24'(shape_cols_reg);
    assign calc_prod = calc_tr ? calc_c[7:0] * shape_rows_reg : calc_r[7:0] * shape_cols_reg;
    assign calc_off  = 19'({calc_prod, 2'b00} >> (2'd2 - sh)) +
                       19'({calc_tr ? calc_r[7:0] : calc_c[7:0], 2'b00} >> (2'd2 - sh)) +
                       19'(calc_b);
    assign calc_off_w    = 32'(calc_off);
    assign calc_in_store = calc_off_w < 32'(PAYLOAD_BYTES);
    assign calc_ok       = calc_in_shape && calc_in_store;

    // emit pipeline: issue stage -> memory read stage -> output register
    logic          v1_reg;
    logic          z1_reg;
    logic [5:0]    slot1_reg;
    logic          last1_reg;
    logic          out_free;
    logic          adv1;
    logic          issue;
    logic          issue_hit;
    logic          resp_load;

    assign out_free  = !m_tvalid || m_tready;
    assign adv1      = v1_reg && out_free;
    assign issue     = is_emit && 32'(emit_counter_reg) < 32'(PACKET_BYTES) &&
                       (!v1_reg || adv1);
    assign issue_hit = 32'(emit_counter_reg) < 32'(total) && calc_ok;
    assign resp_load = state_reg == tpgs_pkg::ST_RESP && out_free;

    // payload memory port
    logic          accept;
    logic          addr_ok;
    logic [31:0]   in_addr_w;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;
    logic          unpack_wr;

    assign accept    = s_tvalid && s_tready;
    assign in_addr_w = 32'(in_addr);
    assign addr_ok   = in_addr_w < 32'(PAYLOAD_BYTES);
    assign unpack_wr = state_reg == tpgs_pkg::ST_DIV4 && div_done && calc_ok;
    assign mem_we    = (accept && in_req == tpgs_pkg::REQ_WRITE && addr_ok) || unpack_wr;
    assign mem_re    = (accept && in_req == tpgs_pkg::REQ_READ && addr_ok) ||
                       (issue && issue_hit);
    assign mem_addr  = accept ? in_addr_w[AW-1:0] : calc_off_w[AW-1:0];
    assign mem_wdata = accept ? in_byte : din_reg;

    tpgs_store #(
        .DEPTH (PAYLOAD_BYTES),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign s_tready = state_reg == tpgs_pkg::ST_IDLE;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tpgs_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_req == tpgs_pkg::REQ_WRITE || in_req == tpgs_pkg::REQ_READ ||
                        reject || oversize) begin
                        state_next = tpgs_pkg::ST_RESP;
                    end else begin
                        state_next = tpgs_pkg::ST_DIV1;
                    end
                end
            end
            tpgs_pkg::ST_DIV1: if (div_done) state_next = tpgs_pkg::ST_DIV2;
            tpgs_pkg::ST_DIV2: if (div_done) state_next = tpgs_pkg::ST_DIV3;
            tpgs_pkg::ST_DIV3: begin
                if (div_done) begin
                    priority if (req_reg == tpgs_pkg::REQ_PACK) begin
                        state_next = tpgs_pkg::ST_EMIT;
                    end else if (12'(slot_reg) < total) begin
                        state_next = tpgs_pkg::ST_DIV4;
                    end else begin
                        state_next = tpgs_pkg::ST_RESP;
                    end
                end
            end
            tpgs_pkg::ST_DIV4: if (div_done) state_next = tpgs_pkg::ST_RESP;
            tpgs_pkg::ST_EMIT: begin
                if (32'(emit_counter_reg) == 32'(PACKET_BYTES) && !v1_reg) begin
                    state_next = tpgs_pkg::ST_IDLE;
                end
            end
            default: if (out_free) state_next = tpgs_pkg::ST_IDLE;
        endcase
    end

    // region update after the third division
    logic [7:0]  grp;
    logic [7:0]  sub;
    logic [12:0] sub_rows;
    logic [12:0] grp_rows;
    logic [12:0] sub_cols;
    logic [23:0] rb_next;
    logic [23:0] cb_next;

    assign grp      = div_quot[7:0];
    assign sub      = div_rmd;
    assign sub_rows = sub * rows_in_packet_reg;
    assign grp_rows = grp * rows_in_packet_reg;
    assign sub_cols = sub * cols_in_packet_reg;

    always_comb begin
        rb_next = region_row_base_reg;
        cb_next = region_col_base_reg;
        unique case (layout_mode_reg)
            tpgs_pkg::LAYOUT_A_LINE: begin
                rb_next = region_row_base_reg + 24'(grp) * 24'(tpgs_pkg::HALF_DIM) +
                          24'(sub_rows);
            end
            tpgs_pkg::LAYOUT_B_LINE: begin
                rb_next = region_row_base_reg + 24'(sub_rows);
                cb_next = region_col_base_reg + 24'(grp) * 24'(tpgs_pkg::HALF_DIM);
            end
            tpgs_pkg::LAYOUT_ROW_MAJOR: begin
                rb_next = region_row_base_reg + 24'(grp_rows);
                cb_next = region_col_base_reg + 24'(sub_cols);
            end
            default: begin
                rb_next = region_row_base_reg + 24'(grp[7:1]) * 24'(tpgs_pkg::HALF_DIM) +
                          24'(sub_rows);
                cb_next = region_col_base_reg + 24'(grp[0]) * 24'(tpgs_pkg::HALF_DIM);
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= tpgs_pkg::ST_IDLE;
            div_start_reg       <= 1'b0;
            emit_counter_reg    <= '0;
            region_row_base_reg <= '0;
            region_col_base_reg <= '0;
            v1_reg              <= 1'b0;
            m_tvalid            <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_start_reg <= 1'b0;
            if (accept && state_next == tpgs_pkg::ST_DIV1) begin
                div_start_reg <= 1'b1;
            end
            if (div_done && (state_next == tpgs_pkg::ST_DIV2 ||
                             state_next == tpgs_pkg::ST_DIV3 ||
                             state_next == tpgs_pkg::ST_DIV4)) begin
                div_start_reg <= 1'b1;
            end
            if (state_reg == tpgs_pkg::ST_DIV2 && div_done) begin
                region_row_base_reg <= 24'({div_quot, 4'b0000});
                region_col_base_reg <= 24'({div_rmd, 4'b0000});
            end
            if (state_reg == tpgs_pkg::ST_DIV3 && div_done) begin
                region_row_base_reg <= rb_next;
                region_col_base_reg <= cb_next;
                emit_counter_reg    <= '0;
            end
            if (issue) begin
                emit_counter_reg <= emit_counter_reg + KW'(1);
                v1_reg           <= 1'b1;
            end else if (adv1) begin
                v1_reg <= 1'b0;
            end
            if (adv1 || resp_load) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg         <= in_req;
            idx_reg         <= in_idx;
            tr_reg          <= in_tr;
            slot_reg        <= in_slot;
            din_reg         <= in_byte;
            resp_rd_reg     <= in_req == tpgs_pkg::REQ_READ && addr_ok;
            resp_slot_reg   <= in_req == tpgs_pkg::REQ_UNPACK ? in_slot : 6'd0;
            if (in_req == tpgs_pkg::REQ_WRITE || in_req == tpgs_pkg::REQ_READ) begin
                resp_status_reg <= tpgs_pkg::STATUS_OK;
            end else if (reject) begin
                resp_status_reg <= tpgs_pkg::STATUS_REJECTED;
            end else if (oversize) begin
                resp_status_reg <= tpgs_pkg::STATUS_OVERSIZE;
            end else begin
                resp_status_reg <= tpgs_pkg::STATUS_OK;
            end
        end
        if (state_reg == tpgs_pkg::ST_DIV1 && div_done) begin
            tile_reg  <= div_quot;
            local_reg <= div_rmd;
        end
        if (state_reg == tpgs_pkg::ST_DIV3 && div_done) begin
            row_cnt_reg <= '0;
            rem_cnt_reg <= '0;
        end
        if (issue) begin
            z1_reg    <= !issue_hit;
            slot1_reg <= 6'(emit_counter_reg);
            last1_reg <= 32'(emit_counter_reg) == 32'(PACKET_BYTES - 1);
            // step to the next byte of the rectangle, wrapping at each row end
            if (rem_cnt_reg + 7'd1 == rowlen) begin
                rem_cnt_reg <= '0;
                row_cnt_reg <= row_cnt_reg + KW'(1);
            end else begin
                rem_cnt_reg <= rem_cnt_reg + 7'd1;
            end
        end
        if (adv1) begin
            m_tuser        <= tpgs_pkg::STATUS_OK;
            m_tdata[7:0]   <= z1_reg ? 8'd0 : mem_rdata;
            m_tdata[13:8]  <= slot1_reg;
            m_tdata[15:14] <= 2'b00;
            m_tlast        <= last1_reg;
        end else if (resp_load) begin
            m_tuser        <= resp_status_reg;
            m_tdata[7:0]   <= resp_rd_reg ? mem_rdata : 8'd0;
            m_tdata[13:8]  <= resp_slot_reg;
            m_tdata[15:14] <= 2'b00;
            m_tlast        <= 1'b1;
        end
    end

    // checks
    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tpgs_pkg::ST_IDLE |-> !v1_reg)
        else $error("emit pipeline busy while idle");

    a_port_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("payload read and write in one cycle");

    a_mid_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> state_reg == tpgs_pkg::ST_EMIT)
        else $error("non-final transfer outside a pack");

endmodule
